FILE: rtl/idllm_pkg.sv
// ----------------------------------------------------------------------------
// idllm_pkg
// Shared types and codes of the indexed doubly linked list manager.
// ----------------------------------------------------------------------------
package idllm_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH_HEAD = 3'd0,
		ACT_PUSH_TAIL = 3'd1,
		ACT_POP_HEAD  = 3'd2,
		ACT_POP_TAIL  = 3'd3,
		ACT_INS_RIGHT = 3'd4,
		ACT_INS_LEFT  = 3'd5,
		ACT_DELETE    = 3'd6,
		ACT_READ      = 3'd7
	} act_t;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_BAD   = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  position;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot;
		logic [63:0] node_value_out;
		logic [7:0]  node_prev_out;
		logic [7:0]  node_next_out;
		logic [7:0]  element_count;
	} rsp_t;

	typedef struct packed {
		act_t        act;
		logic        pos_bad;
		logic [7:0]  pos;
		logic [63:0] value;
	} item_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_CHK,
		ST_TAKE,
		ST_LINK1,
		ST_LINK2,
		ST_POP,
		ST_FREE1,
		ST_FREE2,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/idllm_front.sv
// ----------------------------------------------------------------------------
// idllm_front
// Accepts request beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module idllm_front #(
	parameter int SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  idllm_pkg::req_t    req,
	output logic               q_valid,
	output idllm_pkg::item_t   q_item,
	input  logic               q_take
);

	idllm_pkg::item_t mem_q [2];
	idllm_pkg::item_t cls;
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             do_wr, do_rd;

	always_comb begin
		cls.act     = idllm_pkg::act_t'(req.action);
		cls.pos     = req.position;
		cls.value   = req.value;
		cls.pos_bad = (req.position == 8'd0) || ({24'd0, req.position} >= 32'(SLOTS));
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];
	assign do_wr   = push && !full;
	assign do_rd   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/idllm_back.sv
// ----------------------------------------------------------------------------
// idllm_back
// Sequencer over the node memories: carries out one list operation at a time.
// ----------------------------------------------------------------------------
module idllm_back #(
	parameter int SLOTS      = 256,
	parameter int VALUE_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  idllm_pkg::item_t  q_item,
	output logic              q_take,
	output logic              empty,
	input  logic              pop,
	output idllm_pkg::rsp_t   rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int VB = VALUE_BITS;

	logic [VB-1:0] val_mem [SLOTS];
	logic [IW-1:0] prv_mem [SLOTS];
	logic [IW-1:0] nxt_mem [SLOTS];
	logic          use_mem [SLOTS];

	logic [IW-1:0] raddr;
	logic [VB-1:0] val_rd;
	logic [IW-1:0] prv_rd, nxt_rd;
	logic          use_rd;

	logic          val_we, prv_we, nxt_we, use_we;
	logic [IW-1:0] val_wa, prv_wa, nxt_wa, use_wa;
	logic [VB-1:0] val_wd;
	logic [IW-1:0] prv_wd, nxt_wd;
	logic          use_wd;

	idllm_pkg::state_t st_q, st_d;
	idllm_pkg::item_t  cur_q, cur_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d, cnt_q, cnt_d;
	logic [IW-1:0] clr_q, clr_d, n_q, n_d;
	logic [1:0]    rs_q, rs_d;
	logic [7:0]    rslot_q, rslot_d;
	logic [VB-1:0] rval_q, rval_d;
	logic [IW-1:0] rprv_q, rprv_d, rnxt_q, rnxt_d;
	logic          ov_q, load;
	idllm_pkg::rsp_t out_q;
	logic [IW-1:0] pos_i;

	assign empty = !ov_q;
	assign rsp   = out_q;
	assign pos_i = IW'(cur_q.pos);

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa] <= val_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (use_we) use_mem[use_wa] <= use_wd;
		val_rd <= val_mem[raddr];
		prv_rd <= prv_mem[raddr];
		nxt_rd <= nxt_mem[raddr];
		use_rd <= use_mem[raddr];
	end

	always_comb begin
		st_d    = st_q;
		cur_d   = cur_q;
		head_d  = head_q;
		tail_d  = tail_q;
		free_d  = free_q;
		cnt_d   = cnt_q;
		clr_d   = clr_q;
		n_d     = n_q;
		rs_d    = rs_q;
		rslot_d = rslot_q;
		rval_d  = rval_q;
		rprv_d  = rprv_q;
		rnxt_d  = rnxt_q;
		raddr   = '0;
		q_take  = 1'b0;
		load    = 1'b0;
		val_we  = 1'b0; val_wa = '0; val_wd = '0;
		prv_we  = 1'b0; prv_wa = '0; prv_wd = '0;
		nxt_we  = 1'b0; nxt_wa = '0; nxt_wd = '0;
		use_we  = 1'b0; use_wa = '0; use_wd = 1'b0;
		case (st_q)
			idllm_pkg::ST_CLR: begin
				val_we = 1'b1; val_wa = clr_q; val_wd = '1;
				prv_we = 1'b1; prv_wa = clr_q;
				prv_wd = (clr_q == '0) ? '0 : clr_q - 1'b1;
				nxt_we = 1'b1; nxt_wa = clr_q;
				nxt_wd = (clr_q == '0 || clr_q == IW'(SLOTS - 1)) ? '0 : clr_q + 1'b1;
				use_we = 1'b1; use_wa = clr_q; use_wd = 1'b0;
				clr_d  = clr_q + 1'b1;
				if (clr_q == IW'(SLOTS - 1)) begin
					st_d = idllm_pkg::ST_IDLE;
				end
			end
			idllm_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_take  = 1'b1;
					cur_d   = q_item;
					rs_d    = idllm_pkg::STS_OK;
					rslot_d = 8'd0;
					rval_d  = '0;
					rprv_d  = '0;
					rnxt_d  = '0;
					st_d    = idllm_pkg::ST_DONE;
					case (q_item.act)
						idllm_pkg::ACT_PUSH_HEAD, idllm_pkg::ACT_PUSH_TAIL: begin
							if (free_q == '0) begin
								rs_d = idllm_pkg::STS_FULL;
							end else begin
								raddr = free_q;
								n_d   = free_q;
								st_d  = idllm_pkg::ST_TAKE;
							end
						end
						idllm_pkg::ACT_POP_HEAD: begin
							if (head_q == '0) begin
								rs_d = idllm_pkg::STS_EMPTY;
							end else begin
								raddr = head_q;
								n_d   = head_q;
								st_d  = idllm_pkg::ST_POP;
							end
						end
						idllm_pkg::ACT_POP_TAIL: begin
							if (tail_q == '0) begin
								rs_d = idllm_pkg::STS_EMPTY;
							end else begin
								raddr = tail_q;
								n_d   = tail_q;
								st_d  = idllm_pkg::ST_POP;
							end
						end
						idllm_pkg::ACT_INS_RIGHT, idllm_pkg::ACT_INS_LEFT: begin
							if (free_q == '0) begin
								rs_d = idllm_pkg::STS_FULL;
							end else if (q_item.pos_bad) begin
								rs_d = idllm_pkg::STS_BAD;
							end else begin
								raddr = IW'(q_item.pos);
								st_d  = idllm_pkg::ST_CHK;
							end
						end
						default: begin
							rslot_d = q_item.pos;
							if (q_item.pos_bad) begin
								rs_d = idllm_pkg::STS_BAD;
							end else begin
								raddr = IW'(q_item.pos);
								st_d  = idllm_pkg::ST_CHK;
							end
						end
					endcase
				end
			end
			idllm_pkg::ST_CHK: begin
				if (!use_rd) begin
					rs_d = idllm_pkg::STS_BAD;
					st_d = idllm_pkg::ST_DONE;
				end else begin
					case (cur_q.act)
						idllm_pkg::ACT_INS_RIGHT, idllm_pkg::ACT_INS_LEFT: begin
							raddr = free_q;
							n_d   = free_q;
							rprv_d = prv_rd;
							rnxt_d = nxt_rd;
							st_d  = idllm_pkg::ST_TAKE;
						end
						idllm_pkg::ACT_DELETE: begin
							if (prv_rd != '0) begin
								nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = nxt_rd;
							end else begin
								head_d = nxt_rd;
							end
							if (nxt_rd != '0) begin
								prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = prv_rd;
							end else begin
								tail_d = prv_rd;
							end
							n_d  = pos_i;
							st_d = idllm_pkg::ST_FREE1;
						end
						default: begin
							rval_d = val_rd;
							rprv_d = prv_rd;
							rnxt_d = nxt_rd;
							st_d   = idllm_pkg::ST_DONE;
						end
					endcase
				end
			end
			idllm_pkg::ST_TAKE: begin
				free_d = nxt_rd;
				if (nxt_rd != '0) begin
					prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = '0;
				end
				use_we = 1'b1; use_wa = n_q; use_wd = 1'b1;
				val_we = 1'b1; val_wa = n_q; val_wd = cur_q.value[VB-1:0];
				cnt_d  = cnt_q + 1'b1;
				st_d   = idllm_pkg::ST_LINK1;
			end
			idllm_pkg::ST_LINK1: begin
				prv_we = 1'b1; prv_wa = n_q;
				nxt_we = 1'b1; nxt_wa = n_q;
				case (cur_q.act)
					idllm_pkg::ACT_PUSH_HEAD: begin
						prv_wd = '0;     nxt_wd = head_q;
					end
					idllm_pkg::ACT_PUSH_TAIL: begin
						prv_wd = tail_q; nxt_wd = '0;
					end
					idllm_pkg::ACT_INS_RIGHT: begin
						prv_wd = pos_i;  nxt_wd = rnxt_q;
					end
					default: begin
						prv_wd = rprv_q; nxt_wd = pos_i;
					end
				endcase
				st_d = idllm_pkg::ST_LINK2;
			end
			idllm_pkg::ST_LINK2: begin
				case (cur_q.act)
					idllm_pkg::ACT_PUSH_HEAD: begin
						if (head_q != '0) begin
							prv_we = 1'b1; prv_wa = head_q; prv_wd = n_q;
						end else begin
							tail_d = n_q;
						end
						head_d = n_q;
					end
					idllm_pkg::ACT_PUSH_TAIL: begin
						if (tail_q != '0) begin
							nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = n_q;
						end else begin
							head_d = n_q;
						end
						tail_d = n_q;
					end
					idllm_pkg::ACT_INS_RIGHT: begin
						nxt_we = 1'b1; nxt_wa = pos_i; nxt_wd = n_q;
						if (rnxt_q != '0) begin
							prv_we = 1'b1; prv_wa = rnxt_q; prv_wd = n_q;
						end else begin
							tail_d = n_q;
						end
					end
					default: begin
						prv_we = 1'b1; prv_wa = pos_i; prv_wd = n_q;
						if (rprv_q != '0) begin
							nxt_we = 1'b1; nxt_wa = rprv_q; nxt_wd = n_q;
						end else begin
							head_d = n_q;
						end
					end
				endcase
				rprv_d  = '0;
				rnxt_d  = '0;
				rslot_d = 8'(n_q);
				st_d    = idllm_pkg::ST_DONE;
			end
			idllm_pkg::ST_POP: begin
				if (cur_q.act == idllm_pkg::ACT_POP_HEAD) begin
					if (nxt_rd != '0) begin
						prv_we = 1'b1; prv_wa = nxt_rd; prv_wd = '0;
					end else begin
						tail_d = '0;
					end
					head_d  = nxt_rd;
					rslot_d = 8'(nxt_rd);
				end else begin
					if (prv_rd != '0) begin
						nxt_we = 1'b1; nxt_wa = prv_rd; nxt_wd = '0;
					end else begin
						head_d = '0;
					end
					tail_d  = prv_rd;
					rslot_d = 8'(prv_rd);
				end
				st_d = idllm_pkg::ST_FREE1;
			end
			idllm_pkg::ST_FREE1: begin
				val_we = 1'b1; val_wa = n_q; val_wd = '1;
				prv_we = 1'b1; prv_wa = n_q; prv_wd = '0;
				nxt_we = 1'b1; nxt_wa = n_q; nxt_wd = free_q;
				use_we = 1'b1; use_wa = n_q; use_wd = 1'b0;
				st_d   = idllm_pkg::ST_FREE2;
			end
			idllm_pkg::ST_FREE2: begin
				if (free_q != '0) begin
					prv_we = 1'b1; prv_wa = free_q; prv_wd = n_q;
				end
				free_d = n_q;
				cnt_d  = cnt_q - 1'b1;
				st_d   = idllm_pkg::ST_DONE;
			end
			idllm_pkg::ST_DONE: begin
				if (!ov_q || pop) begin
					load = 1'b1;
					st_d = idllm_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = idllm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		cur_q   <= cur_d;
		n_q     <= n_d;
		rs_q    <= rs_d;
		rslot_q <= rslot_d;
		rval_q  <= rval_d;
		rprv_q  <= rprv_d;
		rnxt_q  <= rnxt_d;
		if (load) begin
			out_q.status         <= rs_q;
			out_q.slot           <= rslot_q;
			out_q.node_value_out <= 64'(rval_q);
			out_q.node_prev_out  <= 8'(rprv_q);
			out_q.node_next_out  <= 8'(rnxt_q);
			out_q.element_count  <= 8'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= idllm_pkg::ST_CLR;
			head_q <= '0;
			tail_q <= '0;
			free_q <= IW'(1);
			cnt_q  <= '0;
			clr_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
			cnt_q  <= cnt_d;
			clr_q  <= clr_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (pop && ov_q) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/indexed_doubly_linked_list_manager.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_manager
// Doubly linked list over a fixed node store, with a linked free list.
// ----------------------------------------------------------------------------
// After reset the block sweeps every slot of its node memories and starts
// no operation until done, though up to two request beats may queue at the
// input meanwhile. Operations then run one at a time through the sequencer,
// which reads and writes one entry per node memory per cycle. A push or
// insert takes a free slot and links it in, a pop or delete unlinks a node
// and frees its slot, and a read returns a node. An operation rejected on a
// full store, an empty list, position zero or a slot not in use skips to its
// result. Each result may then wait to be popped, while up to two further
// operations queue at the input and one result waits in the output register.
module indexed_doubly_linked_list_manager #(
	parameter int SLOTS      = 256,
	parameter int VALUE_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  idllm_pkg::req_t  req,
	output logic             empty,
	input  logic             pop,
	output idllm_pkg::rsp_t  rsp
);

	logic             q_valid, q_take;
	idllm_pkg::item_t q_item;

	idllm_front #(.SLOTS(SLOTS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	idllm_back #(.SLOTS(SLOTS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

FILE: rtl/idllm_checker.sv
// ----------------------------------------------------------------------------
// idllm_checker
// Port-level checks of the list manager's result beats.
// ----------------------------------------------------------------------------
module idllm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input idllm_pkg::req_t  req,
	input logic             empty,
	input logic             pop,
	input idllm_pkg::rsp_t  rsp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(rsp))
		else $error("result beat changed while waiting");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status == idllm_pkg::STS_FULL |-> rsp.slot == 8'd0)
		else $error("store full beat carries a slot");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status == idllm_pkg::STS_EMPTY |->
			rsp.slot == 8'd0 && rsp.element_count == 8'd0)
		else $error("list empty beat with nonzero slot or count");

	a_err_node: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && rsp.status != idllm_pkg::STS_OK |->
			rsp.node_value_out == 64'd0 && rsp.node_prev_out == 8'd0 &&
			rsp.node_next_out == 8'd0)
		else $error("error beat carries node data");

endmodule

bind indexed_doubly_linked_list_manager idllm_checker u_idllm_checker (.*);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives list operations through the request queue and checks every response
// against a behavioral linked-list store kept here, with random handshake gaps.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NODES = 256;
	localparam int RANDOM_OPS = 1530;
	localparam int MAX_CYCLES = 400000;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	idllm_pkg::req_t req;
	logic empty;
	logic pop;
	idllm_pkg::rsp_t rsp;

	indexed_doubly_linked_list_manager i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	logic [63:0] vals[NODES];
	logic [7:0] prv[NODES];
	logic [7:0] nxt[NODES];
	bit live[NODES];
	logic [7:0] head, tail, free_head, count;

	idllm_pkg::rsp_t expected_rsps[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit stim_done = 0;

	typedef struct {
		idllm_pkg::req_t r;
		bit fixed;
		idllm_pkg::rsp_t e;
	} row_t;
	row_t directed[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] take_slot();
		logic [7:0] n;
		n = free_head;
		free_head = nxt[n];
		if (free_head != 0)
			prv[free_head] = 0;
		live[n] = 1;
		count++;
		return n;
	endfunction

	function automatic void free_slot(logic [7:0] s);
		vals[s] = '1;
		prv[s] = 0;
		live[s] = 0;
		if (free_head != 0)
			prv[free_head] = s;
		nxt[s] = free_head;
		free_head = s;
		count--;
	endfunction

	function automatic idllm_pkg::rsp_t apply_op(idllm_pkg::req_t r);
		idllm_pkg::rsp_t o;
		logic [7:0] n, h, nh, pv, nx, p;
		bit ok;
		o = '0;
		p = r.position;
		ok = p != 0 && live[p];
		case (idllm_pkg::act_t'(r.action))
			idllm_pkg::ACT_PUSH_HEAD, idllm_pkg::ACT_PUSH_TAIL: begin
				if (free_head == 0) begin
					o.status = idllm_pkg::STS_FULL;
				end else begin
					n = take_slot();
					vals[n] = r.value;
					if (idllm_pkg::act_t'(r.action) == idllm_pkg::ACT_PUSH_HEAD) begin
						prv[n] = 0;
						nxt[n] = head;
						if (head != 0) prv[head] = n;
						else tail = n;
						head = n;
					end else begin
						nxt[n] = 0;
						prv[n] = tail;
						if (tail != 0) nxt[tail] = n;
						else head = n;
						tail = n;
					end
					o.slot = n;
				end
			end
			idllm_pkg::ACT_POP_HEAD: begin
				if (head == 0) begin
					o.status = idllm_pkg::STS_EMPTY;
				end else begin
					h = head;
					nh = nxt[h];
					if (nh != 0) prv[nh] = 0;
					else tail = 0;
					head = nh;
					free_slot(h);
					o.slot = nh;
				end
			end
			idllm_pkg::ACT_POP_TAIL: begin
				if (tail == 0) begin
					o.status = idllm_pkg::STS_EMPTY;
				end else begin
					h = tail;
					nh = prv[h];
					if (nh != 0) nxt[nh] = 0;
					else head = 0;
					tail = nh;
					free_slot(h);
					o.slot = nh;
				end
			end
			idllm_pkg::ACT_INS_RIGHT, idllm_pkg::ACT_INS_LEFT: begin
				if (free_head == 0) begin
					o.status = idllm_pkg::STS_FULL;
				end else if (!ok) begin
					o.status = idllm_pkg::STS_BAD;
				end else begin
					n = take_slot();
					vals[n] = r.value;
					if (idllm_pkg::act_t'(r.action) == idllm_pkg::ACT_INS_RIGHT) begin
						nx = nxt[p];
						nxt[n] = nx;
						prv[n] = p;
						nxt[p] = n;
						if (nx != 0) prv[nx] = n;
						else tail = n;
					end else begin
						pv = prv[p];
						prv[n] = pv;
						nxt[n] = p;
						prv[p] = n;
						if (pv != 0) nxt[pv] = n;
						else head = n;
					end
					o.slot = n;
				end
			end
			idllm_pkg::ACT_DELETE: begin
				o.slot = p;
				if (!ok) begin
					o.status = idllm_pkg::STS_BAD;
				end else begin
					pv = prv[p];
					nx = nxt[p];
					if (pv != 0) nxt[pv] = nx;
					else head = nx;
					if (nx != 0) prv[nx] = pv;
					else tail = pv;
					free_slot(p);
				end
			end
			default: begin
				o.slot = p;
				if (!ok) begin
					o.status = idllm_pkg::STS_BAD;
				end else begin
					o.node_value_out = vals[p];
					o.node_prev_out = prv[p];
					o.node_next_out = nxt[p];
				end
			end
		endcase
		o.element_count = count;
		return o;
	endfunction

	function automatic logic [7:0] pick_live();
		logic [7:0] s;
		if (count == 0)
			return 8'($urandom_range(0, 255));
		do s = 8'($urandom_range(1, 255)); while (!live[s]);
		return s;
	endfunction

	function automatic idllm_pkg::req_t rand_op(int bias);
		idllm_pkg::req_t r;
		int k;
		r.value = {$urandom, $urandom};
		k = $urandom_range(0, 99);
		// bias > 0 favors growth, < 0 favors shrinking
		if (k < 20 + bias)
			r.action = ($urandom_range(0, 1) != 0) ?
				idllm_pkg::ACT_PUSH_HEAD : idllm_pkg::ACT_PUSH_TAIL;
		else if (k < 40 + bias)
			r.action = ($urandom_range(0, 1) != 0) ?
				idllm_pkg::ACT_INS_RIGHT : idllm_pkg::ACT_INS_LEFT;
		else if (k < 60)
			r.action = ($urandom_range(0, 1) != 0) ?
				idllm_pkg::ACT_POP_HEAD : idllm_pkg::ACT_POP_TAIL;
		else if (k < 75) r.action = idllm_pkg::ACT_DELETE;
		else r.action = idllm_pkg::ACT_READ;
		r.position = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_live();
		return r;
	endfunction

	task automatic send(idllm_pkg::req_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_rsps.push_back(apply_op(r));
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_rsps.size() == 0) begin
				$display("%t unexpected beat %p", $time, rsp);
				errors++;
			end else begin
				idllm_pkg::rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp !== e) begin
					$display("%t expected %p actual %p", $time, e, rsp);
					errors++;
				end
			end
		end
	end

	initial begin
		pop = 0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				pop <= 0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				pop <= 1;
			end
		end
	end

	function automatic void add_row(idllm_pkg::act_t a, logic [7:0] p, logic [63:0] v,
		bit fx, logic [1:0] st, logic [7:0] sl, logic [7:0] cnt);
		row_t w;
		w.r.action = a;
		w.r.position = p;
		w.r.value = v;
		w.fixed = fx;
		w.e = '0;
		w.e.status = st;
		w.e.slot = sl;
		w.e.element_count = cnt;
		directed.push_back(w);
	endfunction

	initial begin
		int phase;
		idllm_pkg::rsp_t pred;
		push = 0;
		req = '0;
		arst_n = 0;
		for (int i = 0; i < NODES; i++) begin
			vals[i] = '1;
			prv[i] = (i == 0) ? 0 : 8'(i - 1);
			nxt[i] = (i == 0) ? 0 : 8'((i + 1) % NODES);
			live[i] = 0;
		end
		head = 0;
		tail = 0;
		free_head = 1;
		count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		add_row(idllm_pkg::ACT_POP_HEAD,  8'd0,   64'd0, 1,
			idllm_pkg::STS_EMPTY, 8'd0, 8'd0);
		add_row(idllm_pkg::ACT_POP_TAIL,  8'd0,   64'd0, 1,
			idllm_pkg::STS_EMPTY, 8'd0, 8'd0);
		add_row(idllm_pkg::ACT_READ,      8'd0,   64'd0, 1,
			idllm_pkg::STS_BAD,   8'd0, 8'd0);
		add_row(idllm_pkg::ACT_DELETE,    8'd255, 64'd0, 1,
			idllm_pkg::STS_BAD,   8'd255, 8'd0);
		add_row(idllm_pkg::ACT_INS_RIGHT, 8'd1,   64'd0, 1,
			idllm_pkg::STS_BAD,   8'd0, 8'd0);
		add_row(idllm_pkg::ACT_PUSH_HEAD, 8'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1,
			idllm_pkg::STS_OK, 8'd1, 8'd1);
		add_row(idllm_pkg::ACT_PUSH_TAIL, 8'd255, 64'd0, 1,
			idllm_pkg::STS_OK, 8'd2, 8'd2);
		add_row(idllm_pkg::ACT_READ,      8'd1,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_INS_RIGHT, 8'd1,   64'h8000_0000_0000_0001, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_INS_LEFT,  8'd1,   64'h0123_4567_89AB_CDEF, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_INS_LEFT,  8'd0,   64'd5, 1,
			idllm_pkg::STS_BAD, 8'd0, 8'd4);
		add_row(idllm_pkg::ACT_READ,      8'd4,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_DELETE,    8'd3,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_READ,      8'd3,   64'd0, 1,
			idllm_pkg::STS_BAD, 8'd3, 8'd3);
		add_row(idllm_pkg::ACT_POP_HEAD,  8'd0,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_POP_TAIL,  8'd0,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_POP_TAIL,  8'd0,   64'd0, 0, 0, 0, 0);
		add_row(idllm_pkg::ACT_POP_TAIL,  8'd0,   64'd0, 1,
			idllm_pkg::STS_EMPTY, 8'd0, 8'd0);

		foreach (directed[i]) begin
			send(directed[i].r);
			pred = expected_rsps[$];
			if (directed[i].fixed && pred !== directed[i].e) begin
				$display("%t expected %p actual %p", $time, directed[i].e, pred);
				errors++;
			end
		end

		// grow the list, send pushes and left inserts, then drain, then mix
		for (int i = 0; i < 262; i++)
			send(rand_op(i < 255 ? 40 : 0));
		for (int i = 0; i < 6; i++) begin
			idllm_pkg::req_t r;
			r = rand_op(0);
			r.action = (i % 2) ? idllm_pkg::ACT_INS_LEFT : idllm_pkg::ACT_PUSH_TAIL;
			r.position = (i < 3) ? 8'd0 : pick_live();
			send(r);
		end
		for (int i = 0; i < 300; i++)
			send(rand_op(-20));
		for (int i = 0; i < RANDOM_OPS - 568; i++) begin
			phase = (i / 200) % 2;
			if (i >= RANDOM_OPS - 568 - 150)
				quiet = 1;
			send(rand_op(phase ? 25 : -10));
		end
		push <= 0;
		quiet = 1;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0 && empty) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

FILE: indexed_doubly_linked_list_manager.f
rtl/idllm_pkg.sv
rtl/idllm_front.sv
rtl/idllm_back.sv
rtl/indexed_doubly_linked_list_manager.sv
rtl/idllm_checker.sv
verif/testbench.sv
